[rtl/pss_pkg.sv]
// Package: constants, types and codes shared by the prime sieve modules.
package pss_pkg;

  localparam int unsigned SIEVE_LEN = 16383;
  localparam int unsigned SPAN      = 2 * SIEVE_LEN;
  localparam int unsigned TOP       = SPAN + 1;

  localparam int unsigned IDX_W   = $clog2(SIEVE_LEN);
  localparam int unsigned CNT_W   = $clog2(SIEVE_LEN + 1);
  localparam int unsigned STEP_W  = $clog2(TOP + 4);
  localparam int unsigned J_W     = STEP_W + 1;
  localparam int unsigned SQ_W    = 2 * STEP_W;
  localparam int unsigned NB_W    = 32;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned PRIME_W = 30;

  // Largest start value still inside the sequence, and largest window base.
  localparam longint unsigned LIMIT  = longint'(TOP) * longint'(TOP);
  localparam longint unsigned NB_MAX = longint'(SPAN) * longint'(SPAN + 1);

  // Reciprocal of SIEVE_LEN, exact for a halved restart dividend of VAL_W - 1 bits
  localparam int unsigned     RECIP_SH = VAL_W - 1 + IDX_W;
  localparam longint unsigned RECIP    =
    ((64'd1 << RECIP_SH) + 64'(SIEVE_LEN) - 64'd1) / 64'(SIEVE_LEN);
  localparam int unsigned     QUO_W    = VAL_W - IDX_W + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_R_CHK, S_R_DIV, S_N_CHK, S_SC_RD, S_SC_CHK, S_SC_NXT,
    S_MW, S_BF, S_BI, S_BT, S_BW, S_BM, S_MW_SET,
    S_WI, S_WF, S_WI2, S_WT, S_WW, S_WD, S_WJ, S_WM, S_RET
  } pss_state_e;

  typedef enum logic [4:0] {
    DP_HOLD, DP_LOAD, DP_SET_EXH, DP_DIV_RST, DP_NB_RST, DP_NB_NEG, DP_NB_ZERO,
    DP_NB_NEXT, DP_LOOP_INIT, DP_FILL_BASE, DP_FILL_WIN, DP_JB, DP_MARK_BASE,
    DP_MARK_WIN, DP_ADV, DP_DIV_STEP, DP_OFF, DP_JW, DP_MW_SET, DP_SET_BUILT,
    DP_SCAN_PEND, DP_SCAN_RD, DP_SCAN_INC, DP_EMIT_PRIME, DP_EMIT_ZERO, DP_EMIT_TWO
  } pss_op_e;

  typedef enum logic [1:0] {
    RET_NONE, RET_PEND, RET_TWO, RET_SCAN
  } pss_ret_e;

  typedef struct packed {
    logic v_gt_lim;
    logic v_le_2;
    logic exh;
    logic wb_valid;
    logic nb_neg;
    logic nb_zero;
    logic nb_eq_wb;
    logic nb_over;
    logic built;
    logic i_last;
    logic go_base;
    logic go_win;
    logic bit_base;
    logic bit_scan;
    logic j_in;
    logic div_busy;
    logic scan_end;
  } pss_stat_t;

endpackage

[rtl/pss_div.sv]
// Restoring divider, one quotient bit per cycle, remainder only.
module pss_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pss_pkg::NB_W-1:0]   dividend_i,
  input  logic [pss_pkg::STEP_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [pss_pkg::STEP_W-1:0] rem_o
);
  import pss_pkg::*;

  localparam int unsigned CW = $clog2(NB_W + 1);

  logic [NB_W-1:0]   dvd_q, dvd_d;
  logic [STEP_W-1:0] dsr_q, dsr_d;
  logic [STEP_W-1:0] rem_q, rem_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [STEP_W:0]   trial;

  // Shift in one dividend bit and subtract where it fits
  always_comb begin
    trial  = {rem_q, dvd_q[NB_W-1]};
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CW'(NB_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[NB_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = STEP_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[STEP_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

[rtl/pss_dp.sv]
// Datapath: sieve memories, loop registers, window state and result register.
module pss_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pss_pkg::pss_op_e            op_i,
  input  logic [pss_pkg::VAL_W-1:0]   start_value_i,
  output pss_pkg::pss_stat_t          stat_o,
  output logic [pss_pkg::PRIME_W-1:0] prime_o,
  output logic                        prime_valid_o
);
  import pss_pkg::*;

  logic [VAL_W-1:0]   v_q;
  logic [NB_W-1:0]    nb_q, wb_q;
  logic               nb_neg_q, wb_valid_q, exh_q, built_q;
  logic [CNT_W-1:0]   scan_q, pend_q, i_q;
  logic [STEP_W-1:0]  step_q;
  logic [SQ_W-1:0]    sq_q;
  logic [J_W-1:0]     j_q;
  logic [STEP_W:0]    off_q;
  logic [PRIME_W-1:0] prime_q;
  logic               pvalid_q;
  logic [QUO_W-1:0]   quo_q;

  logic               base_mem [SIEVE_LEN];
  logic               win_mem  [SIEVE_LEN];
  logic               base_rd_q, win_rd_q;
  logic               base_we, win_we, base_wd, win_wd;
  logic [IDX_W-1:0]   base_wa, win_wa, base_ra;

  logic               div_start, div_busy;
  logic [NB_W-1:0]    div_dvd;
  logic [STEP_W-1:0]  div_dsr, div_rem;
  logic [NB_W-1:0]    rst_dvd;
  logic [63:0]        rst_prod;
  logic [NB_W-1:0]    rst_nb;
  logic [STEP_W-1:0]  dgap;
  logic [63:0]        x_pos, j_far, bound;
  logic [J_W-1:0]     j_new;

  // Restart dividend: start value forced odd, less three
  assign rst_dvd = NB_W'(v_q | VAL_W'(1)) - NB_W'(3);

  // Restart window: halve, scale by the reciprocal of SIEVE_LEN, then back to a base
  assign rst_prod = 64'(rst_dvd >> 1) * RECIP;
  assign rst_nb   = NB_W'(quo_q) * NB_W'(SPAN);

  assign div_start = (op_i == DP_DIV_STEP);
  assign div_dvd   = nb_q + NB_W'(3);
  assign div_dsr   = step_q;

  pss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // Distance to the next multiple, then the first odd multiple at or above step squared
  assign dgap  = (div_rem == '0) ? '0 : step_q - div_rem;
  assign x_pos = 64'(nb_q) + 64'd3 + 64'(off_q);
  assign j_far = (64'(sq_q) - 64'(nb_q) - 64'd3) >> 1;
  assign bound = 64'(nb_q) + 64'(SPAN) + 64'd1;

  always_comb begin
    if (x_pos < 64'(sq_q)) begin
      j_new = (j_far >= 64'(SIEVE_LEN)) ? J_W'(SIEVE_LEN) : j_far[J_W-1:0];
    end else begin
      j_new = J_W'(off_q >> 1);
    end
  end

  // Memory ports
  always_comb begin
    base_we = (op_i == DP_FILL_BASE) || (op_i == DP_MARK_BASE);
    base_wd = (op_i == DP_FILL_BASE);
    base_wa = (op_i == DP_FILL_BASE) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
    win_we  = (op_i == DP_FILL_WIN) || (op_i == DP_MARK_WIN);
    win_wd  = (op_i == DP_FILL_WIN);
    win_wa  = (op_i == DP_FILL_WIN) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
    base_ra = (op_i == DP_SCAN_RD) ? scan_q[IDX_W-1:0] : i_q[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[base_wa] <= base_wd;
    end
    base_rd_q <= base_mem[base_ra];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_wa] <= win_wd;
    end
    win_rd_q <= win_mem[scan_q[IDX_W-1:0]];
  end

  // Control state of the generator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
      exh_q      <= 1'b0;
      built_q    <= 1'b0;
      nb_neg_q   <= 1'b0;
      scan_q     <= '0;
      pvalid_q   <= 1'b0;
    end else begin
      pvalid_q <= 1'b0;
      case (op_i)
        DP_SET_EXH:    exh_q <= 1'b1;
        DP_NB_RST:     nb_neg_q <= 1'b0;
        DP_NB_NEG:     nb_neg_q <= 1'b1;
        DP_NB_ZERO:    nb_neg_q <= 1'b0;
        DP_NB_NEXT:    nb_neg_q <= 1'b0;
        DP_SET_BUILT:  built_q <= 1'b1;
        DP_MW_SET: begin
          scan_q     <= '0;
          exh_q      <= 1'b0;
          wb_valid_q <= !nb_neg_q;
        end
        DP_SCAN_PEND:  scan_q <= pend_q;
        DP_SCAN_INC:   scan_q <= scan_q + 1'b1;
        DP_EMIT_PRIME: begin
          scan_q   <= scan_q + 1'b1;
          pvalid_q <= 1'b1;
        end
        DP_EMIT_ZERO: begin
          exh_q    <= 1'b1;
          pvalid_q <= 1'b1;
        end
        DP_EMIT_TWO:   pvalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload and loop registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      DP_LOAD:       v_q <= start_value_i;
      DP_DIV_RST:    quo_q <= QUO_W'(rst_prod >> RECIP_SH);
      DP_NB_RST: begin
        nb_q   <= rst_nb;
        pend_q <= CNT_W'((rst_dvd - rst_nb) >> 1);
      end
      DP_NB_ZERO:    nb_q <= '0;
      DP_NB_NEXT:    nb_q <= wb_q + NB_W'(SPAN);
      DP_MW_SET: begin
        if (!nb_neg_q) begin
          wb_q <= nb_q;
        end
      end
      DP_LOOP_INIT: begin
        i_q    <= '0;
        step_q <= STEP_W'(3);
        sq_q   <= SQ_W'(9);
      end
      DP_FILL_BASE:  i_q <= i_q + 1'b1;
      DP_FILL_WIN:   i_q <= i_q + 1'b1;
      DP_JB:         j_q <= J_W'((sq_q - SQ_W'(3)) >> 1);
      DP_MARK_BASE:  j_q <= j_q + J_W'(step_q);
      DP_MARK_WIN:   j_q <= j_q + J_W'(step_q);
      DP_ADV: begin
        i_q    <= i_q + 1'b1;
        step_q <= step_q + STEP_W'(2);
        sq_q   <= sq_q + SQ_W'({step_q, 2'b00}) + SQ_W'(4);
      end
      DP_OFF:        off_q <= dgap[0] ? {1'b0, dgap} + {1'b0, step_q} : {1'b0, dgap};
      DP_JW:         j_q <= j_new;
      DP_EMIT_PRIME: prime_q <= PRIME_W'(wb_q + NB_W'({scan_q, 1'b0}) + NB_W'(3));
      DP_EMIT_ZERO:  prime_q <= '0;
      DP_EMIT_TWO:   prime_q <= PRIME_W'(2);
      default: ;
    endcase
  end

  // Status towards the controller
  always_comb begin
    stat_o.v_gt_lim = 64'(v_q) > LIMIT;
    stat_o.v_le_2   = v_q <= VAL_W'(2);
    stat_o.exh      = exh_q;
    stat_o.wb_valid = wb_valid_q;
    stat_o.nb_neg   = nb_neg_q;
    stat_o.nb_zero  = nb_q == '0;
    stat_o.nb_eq_wb = nb_q == wb_q;
    stat_o.nb_over  = 64'(nb_q) > NB_MAX;
    stat_o.built    = built_q;
    stat_o.i_last   = i_q == CNT_W'(SIEVE_LEN - 1);
    stat_o.go_base  = 64'(sq_q) <= 64'(TOP);
    stat_o.go_win   = (64'(sq_q) <= bound) && (i_q != CNT_W'(SIEVE_LEN));
    stat_o.bit_base = base_rd_q;
    stat_o.bit_scan = (wb_q == '0) ? base_rd_q : win_rd_q;
    stat_o.j_in     = j_q < J_W'(SIEVE_LEN);
    stat_o.div_busy = div_busy;
    stat_o.scan_end = scan_q == CNT_W'(SIEVE_LEN);
  end

  assign prime_o       = prime_q;
  assign prime_valid_o = pvalid_q;

endmodule

[rtl/pss_ctrl.sv]
// Controller: sequences transactions, base build, window sieve and scan.
module pss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                command_i,
  input  pss_pkg::pss_stat_t  stat_i,
  output pss_pkg::pss_op_e    op_o,
  output logic                busy
);
  import pss_pkg::*;

  pss_state_e state_q, state_d;
  pss_ret_e   ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_NONE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    op_o    = DP_HOLD;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_o    = DP_LOAD;
          state_d = command_i ? S_R_CHK : S_N_CHK;
        end
      end
      S_R_CHK: begin
        if (stat_i.v_gt_lim) begin
          op_o    = DP_SET_EXH;
          state_d = S_IDLE;
        end else if (stat_i.v_le_2) begin
          op_o    = DP_NB_NEG;
          ret_d   = RET_NONE;
          state_d = S_MW;
        end else begin
          op_o    = DP_DIV_RST;
          state_d = S_R_DIV;
        end
      end
      S_R_DIV: begin
        if (!stat_i.div_busy) begin
          op_o    = DP_NB_RST;
          ret_d   = RET_PEND;
          state_d = S_MW;
        end
      end
      S_N_CHK: begin
        if (stat_i.exh) begin
          op_o    = DP_EMIT_ZERO;
          state_d = S_IDLE;
        end else if (!stat_i.wb_valid) begin
          op_o    = DP_NB_ZERO;
          ret_d   = RET_TWO;
          state_d = S_MW;
        end else begin
          state_d = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (stat_i.scan_end) begin
          op_o    = DP_NB_NEXT;
          state_d = S_SC_NXT;
        end else begin
          op_o    = DP_SCAN_RD;
          state_d = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (stat_i.bit_scan) begin
          op_o    = DP_EMIT_PRIME;
          state_d = S_IDLE;
        end else begin
          op_o    = DP_SCAN_INC;
          state_d = S_SC_RD;
        end
      end
      S_SC_NXT: begin
        if (stat_i.nb_over) begin
          op_o    = DP_EMIT_ZERO;
          state_d = S_IDLE;
        end else begin
          ret_d   = RET_SCAN;
          state_d = S_MW;
        end
      end
      // Build the base sieve once, then move the window
      S_MW: begin
        if (!stat_i.built) begin
          op_o    = DP_LOOP_INIT;
          state_d = S_BF;
        end else begin
          state_d = S_MW_SET;
        end
      end
      S_BF: begin
        op_o = DP_FILL_BASE;
        if (stat_i.i_last) begin
          state_d = S_BI;
        end
      end
      S_BI: begin
        op_o    = DP_LOOP_INIT;
        state_d = S_BT;
      end
      S_BT: begin
        if (!stat_i.go_base) begin
          op_o    = DP_SET_BUILT;
          state_d = S_MW_SET;
        end else begin
          state_d = S_BW;
        end
      end
      S_BW: begin
        if (stat_i.bit_base) begin
          op_o    = DP_JB;
          state_d = S_BM;
        end else begin
          op_o    = DP_ADV;
          state_d = S_BT;
        end
      end
      S_BM: begin
        if (stat_i.j_in) begin
          op_o = DP_MARK_BASE;
        end else begin
          op_o    = DP_ADV;
          state_d = S_BT;
        end
      end
      S_MW_SET: begin
        op_o = DP_MW_SET;
        if (stat_i.nb_neg || stat_i.nb_zero || (stat_i.wb_valid && stat_i.nb_eq_wb)) begin
          state_d = S_RET;
        end else begin
          state_d = S_WI;
        end
      end
      // Sieve a fresh window with the base primes
      S_WI: begin
        op_o    = DP_LOOP_INIT;
        state_d = S_WF;
      end
      S_WF: begin
        op_o = DP_FILL_WIN;
        if (stat_i.i_last) begin
          state_d = S_WI2;
        end
      end
      S_WI2: begin
        op_o    = DP_LOOP_INIT;
        state_d = S_WT;
      end
      S_WT: begin
        state_d = stat_i.go_win ? S_WW : S_RET;
      end
      S_WW: begin
        if (stat_i.bit_base) begin
          op_o    = DP_DIV_STEP;
          state_d = S_WD;
        end else begin
          op_o    = DP_ADV;
          state_d = S_WT;
        end
      end
      S_WD: begin
        if (!stat_i.div_busy) begin
          op_o    = DP_OFF;
          state_d = S_WJ;
        end
      end
      S_WJ: begin
        op_o    = DP_JW;
        state_d = S_WM;
      end
      S_WM: begin
        if (stat_i.j_in) begin
          op_o = DP_MARK_WIN;
        end else begin
          op_o    = DP_ADV;
          state_d = S_WT;
        end
      end
      S_RET: begin
        case (ret_q)
          RET_PEND: begin
            op_o    = DP_SCAN_PEND;
            state_d = S_IDLE;
          end
          RET_TWO: begin
            op_o    = DP_EMIT_TWO;
            state_d = S_IDLE;
          end
          RET_SCAN: state_d = S_SC_RD;
          default:  state_d = S_IDLE;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = state_q != S_IDLE;

endmodule

[rtl/prime_sequence_sieve_top.sv]
// Top level: prime sequence generator over an odd-only segmented sieve.
// A next transaction holds busy while entries are scanned; result follows.
// A reset transaction holds busy while it runs; a new transaction is taken once busy drops.
// Base build on first use: fill, then read each index and, for each prime, strike its multiples.
// Window move: fill, then for each base prime a remainder from the serial divider and a strike of its multiples.
// Reset clears all control state; sieve memories are filled before read; results never stall.
module prime_sequence_sieve_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [pss_pkg::VAL_W-1:0]   start_value_i,
  output logic [pss_pkg::PRIME_W-1:0] prime_o,
  output logic                        prime_valid_o
);
  import pss_pkg::*;

  pss_op_e   op;
  pss_stat_t stat;

  pss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .op_o      (op),
    .busy      (busy)
  );

  pss_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .start_value_i (start_value_i),
    .stat_o        (stat),
    .prime_o       (prime_o),
    .prime_valid_o (prime_valid_o)
  );

endmodule

[rtl/pss_checker.sv]
// Port checker for the prime sieve top level, with its bind.
module pss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [pss_pkg::PRIME_W-1:0] prime_o,
  input logic                        prime_valid_o
);

  // An accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  // A result comes out of a running transaction
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prime_valid_o |-> $past(busy)) else $error("result without transaction");

  // The block is free while a result is shown
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prime_valid_o |-> !busy) else $error("busy during result");

  // Results are odd values, two, or zero
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prime_valid_o |-> (prime_o[0] || prime_o == 2 || prime_o == 0))
    else $error("even non-two result");

endmodule

bind prime_sequence_sieve_top pss_checker u_pss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .prime_o       (prime_o),
  .prime_valid_o (prime_valid_o)
);

[sim/testbench.sv]
// Testbench for the prime sequence sieve: directed table then random commands.
`timescale 1ns / 1ps

module testbench;
  import pss_pkg::*;

  localparam int unsigned N_RANDOM  = 1125;
  localparam longint      SEQ_LIMIT = longint'(LIMIT);
  localparam bit          CMD_NEXT  = 1'b0;
  localparam bit          CMD_SEEK  = 1'b1;

  typedef struct {
    bit     cmd;
    longint val;
    bit     known;
    longint prime;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               command_i = 1'b0;
  logic [VAL_W-1:0]   start_value_i = '0;
  logic [PRIME_W-1:0] prime_o;
  logic               prime_valid_o;

  // Sequence position: next odd candidate, and whether 2 comes first
  longint next_cand = 3;
  bit     two_pending = 1'b1;
  bit     seq_done = 1'b0;

  longint prime_q[$];
  int     mismatches = 0;
  int     idle_pct = 0;

  always #6 clk_i = ~clk_i;

  prime_sequence_sieve_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .start_value_i(start_value_i),
    .prime_o      (prime_o),
    .prime_valid_o(prime_valid_o)
  );

  function automatic bit is_prime(longint q);
    longint d;
    if (q < 2) return 1'b0;
    if (q % 2 == 0) return q == 2;
    for (d = 3; d * d <= q; d += 2) begin
      if (q % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the sequence on a next transaction and return the prime it yields
  function automatic longint advance_sequence();
    longint q;
    if (seq_done) return 0;
    if (two_pending) begin
      two_pending = 1'b0;
      next_cand = 3;
      return 2;
    end
    for (q = next_cand; q <= SEQ_LIMIT; q += 2) begin
      if (is_prime(q)) begin
        next_cand = q + 2;
        return q;
      end
    end
    seq_done = 1'b1;
    return 0;
  endfunction

  // Reposition the sequence on a seek transaction
  function automatic void seek_sequence(longint b);
    if (b > SEQ_LIMIT) begin
      seq_done = 1'b1;
    end else if (b <= 2) begin
      seq_done = 1'b0;
      two_pending = 1'b1;
    end else begin
      seq_done = 1'b0;
      two_pending = 1'b0;
      next_cand = (b % 2 == 0) ? b + 1 : b;
    end
  endfunction

  // Drive one transaction, hold until accepted, then update the model and, for a next, queue its expectation
  task automatic send(bit cmd, longint val, bit known, longint prime);
    longint p;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start         <= 1'b1;
    command_i     <= cmd;
    start_value_i <= val[VAL_W-1:0];
    do @(posedge clk_i); while (busy !== 1'b0);
    if (cmd == CMD_SEEK) begin
      seek_sequence(val);
    end else begin
      p = advance_sequence();
      prime_q.push_back(known ? prime : p);
    end
  endtask

  // Check each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && prime_valid_o === 1'b1) begin
      if (prime_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: prime %0d", prime_o);
      end else if (longint'(prime_o) !== prime_q[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("prime mismatch: expected %0d, got %0d", prime_q[0], prime_o);
        void'(prime_q.pop_front());
      end else begin
        void'(prime_q.pop_front());
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    longint    v;
    int        r;
    int        k;

    rows = '{
      '{CMD_NEXT, 0, 1, 2}, '{CMD_NEXT, 0, 1, 3}, '{CMD_NEXT, 32'h7FFFFFFF, 1, 5},
      '{CMD_SEEK, 0, 0, 0}, '{CMD_NEXT, 0, 1, 2},
      '{CMD_SEEK, 2, 0, 0}, '{CMD_NEXT, 0, 1, 2},
      '{CMD_SEEK, 3, 0, 0}, '{CMD_NEXT, 0, 1, 3},
      '{CMD_SEEK, 4, 0, 0}, '{CMD_NEXT, 0, 1, 5},
      '{CMD_SEEK, 32760, 0, 0}, '{CMD_NEXT, 0, 0, 0}, '{CMD_NEXT, 0, 0, 0},
      '{CMD_NEXT, 0, 0, 0},
      '{CMD_SEEK, SEQ_LIMIT + 1, 0, 0}, '{CMD_NEXT, 0, 1, 0},
      '{CMD_SEEK, 32'h7FFFFFFF, 0, 0}, '{CMD_NEXT, 0, 1, 0},
      '{CMD_SEEK, SEQ_LIMIT - 100, 0, 0}, '{CMD_NEXT, 0, 0, 0}, '{CMD_NEXT, 0, 0, 0},
      '{CMD_NEXT, 0, 0, 0}, '{CMD_NEXT, 0, 0, 0}, '{CMD_NEXT, 0, 0, 0},
      '{CMD_SEEK, 1, 0, 0}, '{CMD_NEXT, 0, 1, 2}
    };

    // Hold reset, then release at a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (rows[i]) send(rows[i].cmd, rows[i].val, rows[i].known, rows[i].prime);

    // Random commands; seeks mostly land in the first window to keep moves rare
    for (k = 0; k < N_RANDOM; k++) begin
      case (k * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 80;
        2: idle_pct = 36;
        default: idle_pct = 0;
      endcase
      r = $urandom_range(99);
      if (r < 55) begin
        send(CMD_NEXT, longint'($urandom()) & 32'h7FFFFFFF, 0, 0);
      end else if (r < 82) begin
        send(CMD_SEEK, $urandom_range(32768, 0), 0, 0);
      end else if (r < 87) begin
        send(CMD_SEEK, $urandom_range(2, 0), 0, 0);
      end else if (r < 92) begin
        v = longint'($urandom_range(32'h7FFFFFFF, 32'd1073676290));
        send(CMD_SEEK, v, 0, 0);
      end else if (r < 94) begin
        send(CMD_SEEK, $urandom_range(65533, 32769), 0, 0);
      end else begin
        send(CMD_NEXT, 0, 0, 0);
      end
    end

    // Drain outstanding results, then allow trailing activity to settle
    @(negedge clk_i);
    start <= 1'b0;
    while (prime_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd12 * 64'd20000000);
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/pss_pkg.sv
rtl/pss_div.sv
rtl/pss_dp.sv
rtl/pss_ctrl.sv
rtl/prime_sequence_sieve_top.sv
rtl/pss_checker.sv
sim/testbench.sv
